// ===== rtl/core/pmmu_pkg.sv =====
// ----------------------------------------------------------------------------
// pmmu_pkg
// Shared types and constants of the paged MMU with LRU replacement.
// ----------------------------------------------------------------------------
package pmmu_pkg;

  localparam int unsigned VaW = 32;
  localparam int unsigned PsW = 17;
  localparam int unsigned ActW = 2;
  localparam int unsigned CntW = 32;
  localparam logic [PsW-1:0] PageSizeReset = 17'd4096;

  typedef enum logic [ActW-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_OTHER = 2'd2,
    ACT_SPARE = 2'd3
  } action_e;

  typedef struct packed {
    logic [31:0] physical_address;
    logic        illegal;
    logic        page_fault;
    logic        evicted;
    logic [5:0]  victim_page;
    logic        victim_dirty;
    logic [2:0]  frame_used;
    logic [31:0] fault_total;
    logic [31:0] writeback_total;
    logic [31:0] read_total;
    logic [31:0] write_total;
    logic [31:0] illegal_total;
  } result_t;

  typedef struct packed {
    logic [VaW-1:0] virtual_address;
    logic [ActW-1:0] action;
  } request_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

// ===== rtl/core/pmmu_if.sv =====
// ----------------------------------------------------------------------------
// pmmu_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface pmmu_req_if;
  logic valid;
  logic ready;
  pmmu_pkg::request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmmu_res_if;
  logic valid;
  logic ready;
  pmmu_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmmu_cfg_if;
  logic valid;
  logic ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/pmmu_div.sv =====
// ----------------------------------------------------------------------------
// pmmu_div
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module pmmu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [16:0] divisor_i,
  output pmmu_pkg::div_ctrl_t ctrl_o,
  output logic [31:0] quot_o,
  output logic [16:0] rem_o
);
  import pmmu_pkg::*;

  logic [31:0] quot_q;
  logic [17:0] rem_q;
  logic [16:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [17:0] shifted;
  logic [17:0] diff;

  assign shifted = {rem_q[16:0], quot_q[31]};
  assign diff = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= (divisor_i == '0) ? 17'd1 : divisor_i;
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_q <= diff;
        quot_q <= {quot_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quot_q <= {quot_q[30:0], 1'b0};
      end
    end
  end

  assign ctrl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quot_q;
  assign rem_o = rem_q[16:0];

endmodule

// ===== rtl/core/paged_mmu_lru_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// paged_mmu_lru_replacement_unit
// Demand-paging address translation with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One reference at a time: a new one is accepted only while idle with no result
// waiting. Each runs through the divider, the check, a serial frame scan and
// eviction when all frames are taken, the address multiply (skipped for an
// illegal page) and the output state.
// Reset clears presence and dirty bits, counters, clock and page size 4096.
module paged_mmu_lru_replacement_unit #(
  parameter int unsigned NUM_PAGES = 64,
  parameter int unsigned NUM_FRAMES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  pmmu_req_if.sink   req,
  pmmu_res_if.source res,
  pmmu_cfg_if.sink   cfg
);
  import pmmu_pkg::*;

  localparam int unsigned PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned AW = $clog2(NUM_FRAMES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_EVICT = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q;
  logic [PsW-1:0] ps_q;
  logic [NUM_PAGES-1:0] present_q, dirty_q;
  logic [FW-1:0] page_frame_q [NUM_PAGES];
  logic [31:0] page_stamp_q [NUM_PAGES];
  logic [PW-1:0] owner_q [NUM_FRAMES];
  logic [AW-1:0] alloc_q;
  logic [31:0] clock_q;
  logic [CntW-1:0] c_ill_q, c_flt_q, c_rd_q, c_wr_q, c_wb_q;
  request_t rq_q;
  logic [31:0] page_q;
  logic [16:0] off_q;
  logic [FW-1:0] frame_q, scan_q, best_q;
  logic [31:0] least_q;
  logic [31:0] stamp_rd_q;
  logic [31:0] prod_q;
  logic fault_q, evict_q, vdirty_q, illegal_q;
  logic [PW-1:0] victim_q;
  result_t res_q;
  logic res_valid_q;

  div_ctrl_t dctl;
  logic [31:0] quot;
  logic [16:0] rem;
  logic div_start;
  logic [PW-1:0] pg;
  logic [PsW-1:0] ps_eff;

  assign req.ready = (state_q == S_IDLE) && !res_valid_q;
  assign cfg.ready = 1'b1;
  assign div_start = req.valid && req.ready;
  assign pg = page_q[PW-1:0];
  assign ps_eff = (ps_q == '0) ? 17'd1 : ps_q;

  pmmu_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(req.data.virtual_address),
    .divisor_i(ps_q), .ctrl_o(dctl), .quot_o(quot), .rem_o(rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ps_q <= PageSizeReset;
      present_q <= '0;
      dirty_q <= '0;
      alloc_q <= '0;
      clock_q <= '0;
      c_ill_q <= '0; c_flt_q <= '0; c_rd_q <= '0; c_wr_q <= '0; c_wb_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg.valid) ps_q <= cfg.data;
      if (res_valid_q && res.ready) res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (div_start) state_q <= S_DIV;
        S_DIV: if (dctl.done) state_q <= S_CHECK;
        S_CHECK: begin
          if (illegal_q) begin
            c_ill_q <= c_ill_q + 32'd1;
            state_q <= S_OUT;
          end else if (present_q[pg]) begin
            state_q <= S_MUL;
          end else begin
            c_flt_q <= c_flt_q + 32'd1;
            if (alloc_q < AW'(NUM_FRAMES)) begin
              alloc_q <= alloc_q + AW'(1);
              present_q[pg] <= 1'b1;
              dirty_q[pg] <= 1'b0;
              state_q <= S_MUL;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: if (scan_q == FW'(NUM_FRAMES - 1)) state_q <= S_EVICT;
        S_EVICT: begin
          if (dirty_q[owner_q[best_q]]) c_wb_q <= c_wb_q + 32'd1;
          present_q[owner_q[best_q]] <= 1'b0;
          present_q[pg] <= 1'b1;
          dirty_q[pg] <= 1'b0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (rq_q.action == ACT_READ) c_rd_q <= c_rd_q + 32'd1;
          if (rq_q.action == ACT_WRITE) begin
            c_wr_q <= c_wr_q + 32'd1;
            dirty_q[pg] <= 1'b1;
          end
          clock_q <= clock_q + 32'd1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          res_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (div_start) rq_q <= req.data;
      S_DIV: if (dctl.done) begin
        page_q <= quot;
        off_q <= rem;
        illegal_q <= (quot >= 32'(NUM_PAGES));
        fault_q <= 1'b0; evict_q <= 1'b0; vdirty_q <= 1'b0; victim_q <= '0;
      end
      S_CHECK: begin
        frame_q <= page_frame_q[pg];
        scan_q <= '0;
        best_q <= '0;
        least_q <= '1;
        stamp_rd_q <= page_stamp_q[owner_q[0]];
        if (!illegal_q && !present_q[pg]) begin
          fault_q <= 1'b1;
          if (alloc_q < AW'(NUM_FRAMES)) begin
            frame_q <= alloc_q[FW-1:0];
            page_frame_q[pg] <= alloc_q[FW-1:0];
            owner_q[alloc_q[FW-1:0]] <= pg;
          end
        end
      end
      S_SCAN: begin
        if (stamp_rd_q <= least_q) begin
          least_q <= stamp_rd_q;
          best_q <= scan_q;
        end
        stamp_rd_q <= page_stamp_q[owner_q[scan_q + FW'(1)]];
        scan_q <= scan_q + FW'(1);
      end
      S_EVICT: begin
        evict_q <= 1'b1;
        victim_q <= owner_q[best_q];
        vdirty_q <= dirty_q[owner_q[best_q]];
        frame_q <= best_q;
        page_frame_q[pg] <= best_q;
        owner_q[best_q] <= pg;
      end
      S_MUL: begin
        prod_q <= 32'(frame_q) * 32'(ps_eff) + 32'(off_q);
        page_stamp_q[pg] <= clock_q;
      end
      S_OUT: begin
        res_q.physical_address <= illegal_q ? '1 : prod_q;
        res_q.illegal <= illegal_q;
        res_q.page_fault <= fault_q;
        res_q.evicted <= evict_q;
        res_q.victim_page <= 6'(victim_q);
        res_q.victim_dirty <= vdirty_q;
        res_q.frame_used <= illegal_q ? 3'd0 : 3'(frame_q);
        res_q.fault_total <= c_flt_q;
        res_q.writeback_total <= c_wb_q;
        res_q.read_total <= c_rd_q;
        res_q.write_total <= c_wr_q;
        res_q.illegal_total <= c_ill_q;
      end
      default: ;
    endcase
  end

  assign res.valid = res_valid_q;
  assign res.data = res_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= AW'(NUM_FRAMES)) else $error("frame count overflow");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res.ready) |=> res_valid_q) else $error("result dropped");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dctl.done |-> (state_q == S_DIV)) else $error("stray divider done");

endmodule
